[sv/tccw_pkg.sv]
`default_nettype none

package tccw_pkg;

   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int CELLS    = COLUMNS * ROWS;
   localparam int TAB_STEP = 4;

   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = 16;
   localparam int POS_W  = 11;
   localparam int CMD_W  = 1;

   localparam int COL_W  = $clog2(COLUMNS + TAB_STEP);
   localparam int ROW_W  = $clog2(ROWS + 1);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

   localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

   localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

endpackage

`default_nettype wire

[sv/tccw_if.sv]
`default_nettype none

interface tccw_req_if;
   import tccw_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [CHAR_W-1:0] char_code;
   logic [POS_W-1:0]  cell_index;
   modport source (output valid, cmd, char_code, cell_index, input ready);
   modport sink   (input valid, cmd, char_code, cell_index, output ready);
endinterface

interface tccw_rsp_if;
   import tccw_pkg::*;
   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  cursor_pos;
   logic [CELL_W-1:0] cell_data;
   logic              scrolled;
   modport source (output valid, cursor_pos, cell_data, scrolled, input ready);
   modport sink   (input valid, cursor_pos, cell_data, scrolled, output ready);
endinterface

interface tccw_csr_if;
   import tccw_pkg::*;
   logic              valid;
   logic              ready;
   logic [ATTR_W-1:0] attribute;
   modport source (output valid, attribute, input ready);
   modport sink   (input valid, attribute, output ready);
endinterface

`default_nettype wire

[sv/text_console_char_writer.sv]
`default_nettype none

// Text console: an 80x25 screen of 16-bit cells (attribute high, character
// low) and a cursor, held in one single-port-write, registered-read RAM.
// After reset the block blanks the screen to 0x0720 before it takes its
// first request; attribute writes are taken at any time. A put goes
// through S_DONE, which loads its response into the output register, and
// a read through S_READ and then S_DONE; the next request is taken once
// the block is back in S_IDLE. A put that moves the cursor past the last
// row scrolls the screen through the RAM port, one cell per cycle: 1920
// copies, then 80 blank fills, before S_DONE loads the response. A
// response that is not taken holds the block until the output register frees.

module text_console_char_writer
   import tccw_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   tccw_req_if.sink   req_chan,
   tccw_rsp_if.source rsp_chan,
   tccw_csr_if.sink   csr_chan
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_SCROLL = 3'd3;
   localparam logic [2:0] S_FILL   = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ATTR_W-1:0] attr_ff;
   logic              copy_valid_ff, copy_valid_in;
   logic [ADDR_W-1:0] copy_addr_ff, copy_addr_in;
   logic              rd_ok_ff, rd_ok_in;

   logic [POS_W-1:0]  res_pos_ff, res_pos_in;
   logic [CELL_W-1:0] res_data_ff, res_data_in;
   logic              res_scroll_ff, res_scroll_in;

   logic              out_valid_ff, out_valid_in;
   logic [POS_W-1:0]  out_pos_ff, out_pos_in;
   logic [CELL_W-1:0] out_data_ff, out_data_in;
   logic              out_scroll_ff, out_scroll_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [CELL_W-1:0] rd_data;

   logic              accept;
   logic [COL_W-1:0]  col_step, col_fin;
   logic [ROW_W-1:0]  row_step, row_fin;
   logic              put_write, need_scroll;
   logic [ADDR_W-1:0] cur_addr, fin_addr;

   tccw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.cursor_pos = out_pos_ff;
   assign rsp_chan.cell_data  = out_data_ff;
   assign rsp_chan.scrolled   = out_scroll_ff;

   assign cur_addr = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   assign fin_addr = ADDR_W'(row_fin) * ADDR_W'(COLUMNS) + ADDR_W'(col_fin);

   // cursor update for a put
   always_comb begin
      col_step    = col_ff;
      row_step    = row_ff;
      put_write   = 1'b0;
      col_fin     = '0;
      row_fin     = '0;
      need_scroll = 1'b0;
      case (req_chan.char_code)
         CH_CR: begin
            col_step = '0;
         end
         CH_LF: begin
            row_step = row_ff + 1'b1;
         end
         CH_TAB: begin
            col_step = col_ff + COL_W'(TAB_STEP);
         end
         CH_BS: begin
            if (col_ff != '0) begin
               col_step = col_ff - 1'b1;
            end
         end
         default: begin
            put_write = 1'b1;
            col_step  = col_ff + 1'b1;
         end
      endcase
      col_fin = col_step;
      row_fin = row_step;
      if (col_step >= COL_W'(COLUMNS)) begin
         col_fin = '0;
         row_fin = row_step + 1'b1;
      end
      if (row_fin >= ROW_W'(ROWS)) begin
         need_scroll = 1'b1;
         row_fin     = ROW_W'(ROWS - 1);
      end
   end

   // RAM port steering
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = BLANK_CELL;
      rd_addr = ADDR_W'(req_chan.cell_index);
      if (copy_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = copy_addr_ff;
         wr_data = rd_data;
      end else if (state_ff == S_CLEAR || state_ff == S_FILL) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff[ADDR_W-1:0];
      end else if (accept && req_chan.cmd == CMD_PUT && put_write) begin
         wr_en   = 1'b1;
         wr_addr = cur_addr;
         wr_data = {attr_ff, req_chan.char_code};
      end
      if (state_ff == S_SCROLL) begin
         rd_addr = cnt_ff[ADDR_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      copy_valid_in = 1'b0;
      copy_addr_in  = copy_addr_ff;
      rd_ok_in      = rd_ok_ff;
      res_pos_in    = res_pos_ff;
      res_data_in   = res_data_ff;
      res_scroll_in = res_scroll_ff;
      out_valid_in  = out_valid_ff;
      out_pos_in    = out_pos_ff;
      out_data_in   = out_data_ff;
      out_scroll_in = out_scroll_ff;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_chan.cmd == CMD_READ) begin
                  rd_ok_in      = 32'(req_chan.cell_index) < 32'(CELLS);
                  res_pos_in    = POS_W'(cur_addr);
                  res_scroll_in = 1'b0;
                  state_in      = S_READ;
               end else begin
                  col_in        = col_fin;
                  row_in        = row_fin;
                  res_pos_in    = POS_W'(fin_addr);
                  res_data_in   = '0;
                  res_scroll_in = need_scroll;
                  cnt_in        = CNT_W'(COLUMNS);
                  state_in      = need_scroll ? S_SCROLL : S_DONE;
               end
            end
         end
         S_READ: begin
            res_data_in = rd_ok_ff ? rd_data : '0;
            state_in    = S_DONE;
         end
         S_SCROLL: begin
            // read cell n, write it back one row up on the next cycle
            if (cnt_ff < CNT_W'(CELLS)) begin
               copy_valid_in = 1'b1;
               copy_addr_in  = ADDR_W'(cnt_ff - CNT_W'(COLUMNS));
               cnt_in        = cnt_ff + 1'b1;
            end else begin
               cnt_in   = CNT_W'(CELLS - COLUMNS);
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CELLS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in  = 1'b1;
               out_pos_in    = res_pos_ff;
               out_data_in   = res_data_ff;
               out_scroll_in = res_scroll_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         cnt_ff        <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         attr_ff       <= ATTR_RESET;
         copy_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         copy_valid_ff <= copy_valid_in;
         out_valid_ff  <= out_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            attr_ff <= csr_chan.attribute;
         end
      end
   end

   always_ff @(posedge clock) begin
      copy_addr_ff  <= copy_addr_in;
      rd_ok_ff      <= rd_ok_in;
      res_pos_ff    <= res_pos_in;
      res_data_ff   <= res_data_in;
      res_scroll_ff <= res_scroll_in;
      out_pos_ff    <= out_pos_in;
      out_data_ff   <= out_data_in;
      out_scroll_ff <= out_scroll_in;
   end

endmodule

`default_nettype wire

[sv/tccw_ram.sv]
`default_nettype none

module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[tb/sv/tb_text_console_char_writer.sv]
`timescale 1ns / 1ps

module tb_text_console_char_writer;
   import tccw_pkg::*;

   localparam int IDLE_LIMIT  = 20000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_pos;
      logic [CELL_W-1:0] cell_data;
      logic              scrolled;
   } console_view_type;

   logic clock;
   logic reset;

   tccw_req_if req_bus ();
   tccw_rsp_if rsp_bus ();
   tccw_csr_if csr_bus ();

   text_console_char_writer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // screen and cursor as the block should hold them
   logic [CELL_W-1:0] screen_model [CELLS];
   int unsigned       cur_col;
   int unsigned       cur_row;
   logic [ATTR_W-1:0] attr_model;

   console_view_type views_due [$];
   int               mismatches;
   int               burst_left;
   bit               hold_rsp;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void reset_console_model();
      for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
      cur_col    = 0;
      cur_row    = 0;
      attr_model = ATTR_RESET;
   endfunction

   function automatic console_view_type apply_console_item(input logic [CMD_W-1:0]  cmd,
                                                           input logic [CHAR_W-1:0] ch,
                                                           input logic [POS_W-1:0]  idx);
      console_view_type v;
      v = '0;
      if (cmd == CMD_READ) begin
         if (idx < CELLS) v.cell_data = screen_model[idx];
      end else begin
         case (ch)
            CH_CR: begin
               cur_col = 0;
            end
            CH_LF: begin
               cur_row++;
            end
            CH_TAB: begin
               cur_col += TAB_STEP;
            end
            CH_BS: begin
               if (cur_col > 0) cur_col--;
            end
            default: begin
               if (cur_col < COLUMNS && cur_row < ROWS)
                  screen_model[cur_row * COLUMNS + cur_col] = {attr_model, ch};
               cur_col++;
            end
         endcase
         if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
         end
         if (cur_row >= ROWS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
            cur_row    = ROWS - 1;
            v.scrolled = 1'b1;
         end
      end
      v.cursor_pos = POS_W'(cur_row * COLUMNS + cur_col);
      return v;
   endfunction

   task automatic send_item(input logic [CMD_W-1:0]  cmd,
                            input logic [CHAR_W-1:0] ch,
                            input logic [POS_W-1:0]  idx);
      if (burst_left == 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.char_code  <= ch;
      req_bus.cell_index <= idx;
      do @(posedge clock); while (!req_bus.ready);
      views_due.push_back(apply_console_item(cmd, ch, idx));
      burst_left--;
   endtask

   task automatic put_char(input logic [CHAR_W-1:0] ch);
      send_item(CMD_PUT, ch, POS_W'($urandom_range(0, 2047)));
   endtask

   task automatic read_cell(input logic [POS_W-1:0] idx);
      send_item(CMD_READ, CHAR_W'($urandom_range(0, 255)), idx);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (views_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      @(negedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.attribute <= value;
      do @(posedge clock); while (!csr_bus.ready);
      attr_model = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic test_blank_screen();
      read_cell(POS_W'(0));
      read_cell(POS_W'(CELLS));
      read_cell(POS_W'(2047));
      wait_drained();
   endtask

   task automatic test_backspace_and_extremes();
      put_char(CH_BS);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(CH_BS);
      wait_drained();
   endtask

   // column 1 plus 19 tabs lands on 77, the next tab overshoots the edge
   task automatic test_tab_wrap();
      repeat (20) put_char(CH_TAB);
      put_char(CH_CR);
      put_char(CH_LF);
      wait_drained();
   endtask

   task automatic test_input_stall();
      hold_rsp = 1'b1;
      for (int k = 0; k < 24; k++) begin
         if (k % 6 == 5) read_cell(POS_W'(cur_row * COLUMNS + cur_col));
         else put_char(CHAR_W'(8'h41 + k));
      end
      wait_drained();
   endtask

   task automatic test_random_typing(input int n);
      int roll;
      for (int k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            if ($urandom_range(0, 3) == 0) read_cell(POS_W'($urandom_range(0, 2047)));
            else read_cell(POS_W'(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1)));
         end else if (roll < 24) put_char(CH_LF);
         else if (roll < 28) put_char(CH_CR);
         else if (roll < 36) put_char(CH_TAB);
         else if (roll < 44) put_char(CH_BS);
         else put_char(CHAR_W'($urandom_range(0, 255)));
      end
      wait_drained();
   endtask

   // receiver: free-flowing and choppy stretches, plus one long hold on request
   initial begin
      int  mode_left;
      bit  free_run;
      mode_left     = 0;
      free_run      = 1'b1;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(1, 40);
               free_run  = ($urandom_range(0, 2) == 0);
            end
            mode_left--;
            rsp_bus.ready <= free_run ? 1'b1 : ($urandom_range(0, 2) != 0);
         end
      end
   end

   always @(posedge clock) begin
      console_view_type got;
      console_view_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.cursor_pos, rsp_bus.cell_data, rsp_bus.scrolled};
         if (views_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: cursor %0d cell %h scrolled %b",
                        got.cursor_pos, got.cell_data, got.scrolled);
         end else begin
            want = views_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: cursor %0d/%0d cell %h/%h scrolled %b/%b (exp/act)",
                           want.cursor_pos, got.cursor_pos, want.cell_data, got.cell_data,
                           want.scrolled, got.scrolled);
            end
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb_text_console_char_writer: done, errors");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = CMD_PUT;
      req_bus.char_code  = '0;
      req_bus.cell_index = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.attribute  = '0;
      mismatches         = 0;
      burst_left         = 0;
      hold_rsp           = 1'b0;
      reset_console_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_blank_screen();
      write_attribute(8'hFF);
      test_backspace_and_extremes();
      test_tab_wrap();
      write_attribute(8'h00);
      test_input_stall();
      write_attribute(ATTR_W'($urandom_range(1, 254)));
      test_random_typing(70);
      write_attribute(8'hFF);
      test_random_typing(70);
      write_attribute(ATTR_W'($urandom_range(0, 255)));
      test_random_typing(70);
      write_attribute(ATTR_RESET);
      test_random_typing(70);

      mismatches += views_due.size();
      if (mismatches == 0)
         $display("tb_text_console_char_writer: done, clean");
      else
         $display("tb_text_console_char_writer: done, errors");
      $finish;
   end

endmodule

[text_console_char_writer.f]
sv/tccw_pkg.sv
sv/tccw_if.sv
sv/tccw_ram.sv
sv/text_console_char_writer.sv
tb/sv/tb_text_console_char_writer.sv
